@@ design/snd_pkg.sv @@
package snd_pkg;

	localparam int DEF_NUM_BINS  = 21;
	localparam int DEF_BIN_WIDTH = 10;
	localparam int WORD_W        = 32;
	localparam int LOG_WORD_W    = $clog2(WORD_W);
	localparam int BIN_MAX_W     = 5;
	localparam int LUT_DEPTH     = 256;

	typedef logic [BIN_MAX_W-1:0] bin_lut_t [LUT_DEPTH];

	typedef struct packed {
		logic load;
		logic bin;
		logic mix;
		logic idx;
		logic rd;
		logic upd;
		logic clr;
	} snd_cmd_t;

	typedef struct packed {
		logic clr_last;
	} snd_status_t;

	function automatic bin_lut_t make_bin_lut(int n, int bw);
		bin_lut_t lut;
		int b;
		int r;
		int x;
		b = 0;
		r = 0;
		for (x = 0; x < LUT_DEPTH; x++) begin
			lut[x] = (b > n - 1) ? BIN_MAX_W'(n - 1) : BIN_MAX_W'(b);
			r++;
			if (r == bw) begin
				r = 0;
				b++;
			end
		end
		return lut;
	endfunction

endpackage

@@ design/sensor_novelty_detector.sv @@
// Sensor novelty detector.
// Input: four distance readings dist_a..dist_d; a transaction is taken at a
// rising edge where start is high and busy is low.
// Each reading is binned, the four bins form an index into a visited bitmap
// held in a single-port word RAM (32 bits per row), and the bit is tested and
// set by a read-modify-write of its row.
// Output: is_novel and boredom, valid for exactly one cycle while done is
// high. The receiver cannot stall; results must be taken when shown.
// Sequence: after the accepting cycle, done rises once the sequencer has gone
// through its steps: bin lookup, two mixed-radix multiply-add steps, the RAM
// read and the update. A new transaction is not taken until then.
// busy drops in the cycle done is high, so the next start may be taken then.
// Reset: the boredom counter clears, then a clearing pass writes zero to
// every RAM row, one row per cycle: ceil(NUM_BINS^4 / 32) rows, 6078 at the
// default settings. busy stays high during the pass.
module sensor_novelty_detector
	import snd_pkg::*;
#(
	parameter int NUM_BINS  = DEF_NUM_BINS,
	parameter int BIN_WIDTH = DEF_BIN_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  dist_a,
	input  logic [7:0]  dist_b,
	input  logic [7:0]  dist_c,
	input  logic [7:0]  dist_d,
	output logic        done,
	output logic        is_novel,
	output logic [15:0] boredom
);

	snd_cmd_t    cmd;
	snd_status_t status;

	snd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	snd_datapath #(
		.NUM_BINS  (NUM_BINS),
		.BIN_WIDTH (BIN_WIDTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.dist_a   (dist_a),
		.dist_b   (dist_b),
		.dist_c   (dist_c),
		.dist_d   (dist_d),
		.is_novel (is_novel),
		.boredom  (boredom)
	);

`ifndef ASSERT_OFF
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held for more than one cycle");

	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("busy not raised after accepted transaction");

	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(cmd.upd))
		else $error("result shown without a preceding update");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_novel) |-> (boredom == 16'd0))
		else $error("novel result with nonzero boredom");
`endif

endmodule

@@ design/snd_ctrl.sv @@
module snd_ctrl
	import snd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  snd_status_t status,
	output snd_cmd_t    cmd,
	output logic        busy,
	output logic        done
);

	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_BIN    = 7'b0000100,
		ST_MIX    = 7'b0001000,
		ST_IDX    = 7'b0010000,
		ST_READ   = 7'b0100000,
		ST_UPDATE = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (status.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_BIN;
				end
			end
			ST_BIN: begin
				cmd.bin = 1'b1;
				state_d = ST_MIX;
			end
			ST_MIX: begin
				cmd.mix = 1'b1;
				state_d = ST_IDX;
			end
			ST_IDX: begin
				cmd.idx = 1'b1;
				state_d = ST_READ;
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.upd = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_UPDATE);
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

@@ design/snd_datapath.sv @@
module snd_datapath
	import snd_pkg::*;
#(
	parameter int NUM_BINS  = DEF_NUM_BINS,
	parameter int BIN_WIDTH = DEF_BIN_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  snd_cmd_t    cmd,
	output snd_status_t status,
	input  logic [7:0]  dist_a,
	input  logic [7:0]  dist_b,
	input  logic [7:0]  dist_c,
	input  logic [7:0]  dist_d,
	output logic        is_novel,
	output logic [15:0] boredom
);

	localparam int BW       = (NUM_BINS > 2) ? $clog2(NUM_BINS) : 1;
	localparam int NN       = NUM_BINS * NUM_BINS;
	localparam int MAP_BITS = NN * NN;
	localparam int IW_RAW   = $clog2(MAP_BITS);
	localparam int IW       = (IW_RAW > LOG_WORD_W) ? IW_RAW : LOG_WORD_W + 1;
	localparam int ROWS     = (MAP_BITS + WORD_W - 1) / WORD_W;
	localparam int RAW      = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam bin_lut_t LUT = make_bin_lut(NUM_BINS, BIN_WIDTH);

	logic [7:0]        dist_a_q, dist_b_q, dist_c_q, dist_d_q;
	logic [BW-1:0]     bin_a_q, bin_b_q, bin_c_q, bin_d_q;
	logic [IW-1:0]     ab_q, cd_q, idx_q;
	logic [WORD_W-1:0] rd_data_q;
	logic [RAW-1:0]    clr_addr_q;
	logic [15:0]       boredom_q;
	logic              is_novel_q;
	logic [WORD_W-1:0] mem [ROWS];

	logic [RAW-1:0]    row;
	logic              seen;
	logic              we;
	logic [RAW-1:0]    waddr;
	logic [WORD_W-1:0] wdata;

	assign row   = RAW'(idx_q >> LOG_WORD_W);
	assign seen  = rd_data_q[idx_q[LOG_WORD_W-1:0]];
	assign we    = cmd.clr | cmd.upd;
	assign waddr = cmd.clr ? clr_addr_q : row;
	assign wdata = cmd.clr ? '0
		: (rd_data_q | (WORD_W'(1) << idx_q[LOG_WORD_W-1:0]));

	assign status.clr_last = (clr_addr_q == RAW'(ROWS - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dist_a_q <= dist_a;
			dist_b_q <= dist_b;
			dist_c_q <= dist_c;
			dist_d_q <= dist_d;
		end
		if (cmd.bin) begin
			bin_a_q <= LUT[dist_a_q][BW-1:0];
			bin_b_q <= LUT[dist_b_q][BW-1:0];
			bin_c_q <= LUT[dist_c_q][BW-1:0];
			bin_d_q <= LUT[dist_d_q][BW-1:0];
		end
		if (cmd.mix) begin
			ab_q <= IW'(IW'(bin_a_q) * NUM_BINS) + IW'(bin_b_q);
			cd_q <= IW'(IW'(bin_c_q) * NUM_BINS) + IW'(bin_d_q);
		end
		if (cmd.idx) begin
			idx_q <= IW'(ab_q * NN) + cd_q;
		end
		if (cmd.rd) begin
			rd_data_q <= mem[row];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			boredom_q  <= '0;
			is_novel_q <= 1'b0;
		end else begin
			if (cmd.clr) clr_addr_q <= clr_addr_q + 1'b1;
			if (cmd.upd) begin
				is_novel_q <= ~seen;
				if (!seen) begin
					boredom_q <= '0;
				end else if (boredom_q != '1) begin
					boredom_q <= boredom_q + 1'b1;
				end
			end
		end
	end

	assign is_novel = is_novel_q;
	assign boredom  = boredom_q;

endmodule

@@ tb/tb_sensor_novelty_detector.sv @@
module tb_sensor_novelty_detector;
	import snd_pkg::*;

	localparam int N_BINS      = DEF_NUM_BINS;
	localparam int BIN_W       = DEF_BIN_WIDTH;
	localparam int TOP_BIN     = N_BINS - 1;
	localparam int MAP_SIZE    = N_BINS * N_BINS * N_BINS * N_BINS;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_WAIT  = 12;

	typedef struct packed {
		logic        novel;
		logic [15:0] boredom;
	} visit_outcome_t;

	typedef logic [4:0] bin_t;
	typedef logic [19:0] situation_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [7:0]  dist_a = '0;
	logic [7:0]  dist_b = '0;
	logic [7:0]  dist_c = '0;
	logic [7:0]  dist_d = '0;
	logic        busy;
	logic        done;
	logic        is_novel;
	logic [15:0] boredom;

	bit             seen_map [MAP_SIZE];
	logic [15:0]    boredom_model = '0;
	visit_outcome_t outcome_q [$];
	situation_t     visited_q [$];
	situation_t     last_situation;
	bit             idle_en = 1'b0;
	int             mismatch_count = 0;
	int             cycle_count = 0;

	sensor_novelty_detector dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.dist_a   (dist_a),
		.dist_b   (dist_b),
		.dist_c   (dist_c),
		.dist_d   (dist_d),
		.done     (done),
		.is_novel (is_novel),
		.boredom  (boredom)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic bin_t reading_bin(logic [7:0] reading);
		int b;
		b = int'(reading) / BIN_W;
		if (b > TOP_BIN)
			b = TOP_BIN;
		return bin_t'(b);
	endfunction

	function automatic logic [7:0] reading_in_bin(bin_t b);
		if (int'(b) >= TOP_BIN)
			return 8'($urandom_range(TOP_BIN * BIN_W, 255));
		return 8'(int'(b) * BIN_W + $urandom_range(0, BIN_W - 1));
	endfunction

	function automatic visit_outcome_t predict_visit(logic [7:0] a, logic [7:0] b,
			logic [7:0] c, logic [7:0] d);
		visit_outcome_t res;
		int slot;
		slot = int'(reading_bin(a));
		slot = slot * N_BINS + int'(reading_bin(b));
		slot = slot * N_BINS + int'(reading_bin(c));
		slot = slot * N_BINS + int'(reading_bin(d));
		res.novel = !seen_map[slot];
		seen_map[slot] = 1'b1;
		if (res.novel)
			boredom_model = '0;
		else if (boredom_model != 16'hFFFF)
			boredom_model = boredom_model + 16'd1;
		res.boredom = boredom_model;
		return res;
	endfunction

	task automatic send_reading(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c, input logic [7:0] d);
		start  <= 1'b1;
		dist_a <= a;
		dist_b <= b;
		dist_c <= c;
		dist_d <= d;
		do @(posedge clk); while (busy);
		outcome_q.insert(outcome_q.size(), predict_visit(a, b, c, d));
		last_situation = {reading_bin(a), reading_bin(b), reading_bin(c), reading_bin(d)};
		visited_q.insert(visited_q.size(), last_situation);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic send_situation(input situation_t s);
		send_reading(reading_in_bin(s[19:15]), reading_in_bin(s[14:10]),
			reading_in_bin(s[9:5]), reading_in_bin(s[4:0]));
	endtask

	always @(posedge clk) begin
		visit_outcome_t want;
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				$display("%0t: unexpected result is_novel %0d boredom %0d",
					$time, is_novel, boredom);
				mismatch_count++;
			end else begin
				want = outcome_q.pop_front();
				if (is_novel !== want.novel) begin
					$display("%0t: is_novel expected %0d got %0d",
						$time, want.novel, is_novel);
					mismatch_count++;
				end
				if (boredom !== want.boredom) begin
					$display("%0t: boredom expected %0d got %0d",
						$time, want.boredom, boredom);
					mismatch_count++;
				end
			end
		end
	end

	task automatic test_field_extremes;
		idle_en = 1'b1;
		send_reading(8'd0, 8'd0, 8'd0, 8'd0);
		send_reading(8'd0, 8'd0, 8'd0, 8'd0);
		send_reading(8'd9, 8'd9, 8'd9, 8'd9);
		send_reading(8'd10, 8'd0, 8'd0, 8'd0);
		send_reading(8'd0, 8'd0, 8'd0, 8'd19);
		send_reading(8'd199, 8'd190, 8'd199, 8'd190);
		send_reading(8'd200, 8'd200, 8'd200, 8'd200);
		send_reading(8'd255, 8'd255, 8'd255, 8'd255);
		send_reading(8'd201, 8'd230, 8'd254, 8'd209);
		send_reading(8'd255, 8'd0, 8'd255, 8'd0);
		send_reading(8'd0, 8'd255, 8'd0, 8'd255);
		send_reading(8'd200, 8'd9, 8'd210, 8'd5);
		send_reading(8'hAA, 8'h55, 8'hAA, 8'h55);
		send_reading(8'h55, 8'hAA, 8'h55, 8'hAA);
		send_reading(8'h0F, 8'hF0, 8'h0F, 8'hF0);
		send_reading(8'h0F, 8'hF0, 8'h0F, 8'hF0);
		send_reading(8'd100, 8'd101, 8'd109, 8'd100);
	endtask

	task automatic test_boredom_limit;
		idle_en = 1'b0;
		repeat (30)
			send_reading(8'd3, 8'd7, 8'd2, 8'd0);
		send_reading(8'd50, 8'd60, 8'd70, 8'd80);
		send_reading(8'd59, 8'd69, 8'd79, 8'd89);
	endtask

	task automatic test_random_situations(input int count, input bit with_idle);
		situation_t s;
		int mode;
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0)
				idle_en = with_idle && ($urandom_range(0, 2) != 0);
			mode = $urandom_range(0, 9);
			if (mode <= 3) begin
				s = visited_q[$urandom_range(0, visited_q.size() - 1)];
				send_situation(s);
			end else if (mode <= 5) begin
				send_situation(last_situation);
			end else if (mode <= 7) begin
				s = {bin_t'($urandom_range(0, 2)), bin_t'($urandom_range(18, 20)),
					bin_t'($urandom_range(0, 2)), bin_t'($urandom_range(18, 20))};
				send_situation(s);
			end else begin
				send_reading(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_field_extremes();
		test_boredom_limit();
		test_random_situations(550, 1'b1);
		test_random_situations(100, 1'b0);
		start <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
